// ===== src/dbc_pkg.sv =====
// Shared types, constants and helpers of the dictionary bitmask code decompressor.
// Used by the channel interfaces, the parser, the queue and the word builder.
`default_nettype none

package dbc_pkg;

    localparam int WORD_W      = 32;
    localparam int BUF_W       = 66;   // leftover bits plus one stream word
    localparam int LEFT_MAX    = 34;   // longest incomplete code kept across words
    localparam int CNT_W       = 7;    // holds 0 .. BUF_W
    localparam int LEN_W       = 6;    // holds the longest code length
    localparam int DICT_DEPTH  = 8;
    localparam int DICT_IDX_W  = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int RES_CNT_W   = 5;    // holds 0 .. MAX_RESULTS
    localparam int MAX_RESULTS = 28;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = 2;
    localparam int FIFO_CNT_W  = 3;

    typedef enum logic [2:0] {
        FMT_REPEAT = 3'b000,
        FMT_MASK   = 3'b001,
        FMT_FLIP   = 3'b010,
        FMT_ADJ    = 3'b011,
        FMT_TWO    = 3'b100,
        FMT_DIRECT = 3'b101,
        FMT_RAW    = 3'b110,
        FMT_STOP   = 3'b111
    } fmt_t;

    typedef enum logic [1:0] {
        OP_WORD,
        OP_REPEAT,
        OP_END
    } op_kind_t;

    typedef enum logic {
        FE_IDLE,
        FE_PARSE
    } fe_state_t;

    // One queued job for the word builder.
    typedef struct packed {
        op_kind_t              kind;
        logic                  use_dict;
        logic [DICT_IDX_W-1:0] dict_idx;
        logic [WORD_W-1:0]     value;       // flip mask, or the raw word
        logic [1:0]            rep_cnt_m1;  // repeat count minus one
    } dbc_op_t;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [WORD_W-1:0]    data;
    } cfg_wr_t;

    // Code length in bits for a format; zero for the stop format.
    function automatic logic [LEN_W-1:0] code_length(input fmt_t fmt);
        logic [LEN_W-1:0] len;
        unique case (fmt)
            FMT_REPEAT: len = LEN_W'(5);
            FMT_MASK:   len = LEN_W'(15);
            FMT_FLIP:   len = LEN_W'(11);
            FMT_ADJ:    len = LEN_W'(11);
            FMT_TWO:    len = LEN_W'(16);
            FMT_DIRECT: len = LEN_W'(6);
            FMT_RAW:    len = LEN_W'(35);
            FMT_STOP:   len = LEN_W'(0);
            default:    len = LEN_W'(0);
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== src/dbc_in_if.sv =====
// Input channel of the decompressor: one compressed stream word per request.
// Depends on dbc_pkg for the word width.
`default_nettype none

interface dbc_in_if;
    logic                      valid;
    logic                      ready;
    logic [dbc_pkg::WORD_W-1:0] stream_word;

    modport source (output valid, output stream_word, input ready);
    modport sink   (input valid, input stream_word, output ready);
endinterface

`default_nettype wire

// ===== src/dbc_out_if.sv =====
// Output channel of the decompressor: one decoded instruction word per request.
// Depends on dbc_pkg for the word width.
`default_nettype none

interface dbc_out_if;
    logic                      valid;
    logic                      ready;
    logic [dbc_pkg::WORD_W-1:0] decoded_word;
    logic                      last_of_run;

    modport source (output valid, output decoded_word, output last_of_run, input ready);
    modport sink   (input valid, input decoded_word, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== src/dictionary_bitmask_code_decompressor.sv =====
// Top level of the dictionary bitmask code decompressor.
// Depends on dbc_pkg, dbc_in_if, dbc_out_if, dbc_front, dbc_fifo and dbc_back.
//
// Use:
//   stream : valid/ready channel of 32-bit compressed words, first stream bit
//            in bit 31. A request is taken when valid and ready are both high.
//   result : valid/ready channel of decoded instruction words; last_of_run
//            marks the final word caused by one stream word.
//   cfg_we / cfg_index / cfg_data : dictionary writes, one per cycle, only
//            while the block is idle.
// Timing: the parser takes a stream word, then handles each complete code in turn
//   and closes the word with an end job; it takes no new stream word before
//   that. The builder emits one result a cycle while jobs are queued and the
//   receiver takes them; a repeat code yields its repeated words in turn. A
//   result passes the bit buffer, the job queue, the held result and the output
//   register; the last of a run follows its predecessor once the closing job
//   reaches the builder.
// Reset clears the bit buffer, the dictionary, the previous word and the stop
//   flag at once; there is no clearing pass. After a stop code every stream
//   word is taken and dropped until reset.
// A stalled receiver fills the output register, then the held result, then the
//   four-entry job queue, then stalls the parser; stream ready is low while it parses.
`default_nettype none

module dictionary_bitmask_code_decompressor (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [dbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [dbc_pkg::WORD_W-1:0]    cfg_data,
    dbc_in_if.sink                             stream,
    dbc_out_if.source                          result
);

    dbc_pkg::cfg_wr_t cfg;
    dbc_pkg::dbc_op_t push_data, pop_data;
    logic             push_valid, push_ready;
    logic             pop_valid, pop_ready;

    // bundle the dictionary write for the builder
    always_comb
    begin
        cfg.we    = cfg_we;
        cfg.index = cfg_index;
        cfg.data  = cfg_data;
    end

    // parse codes and classify them into jobs
    dbc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (stream.valid),
        .in_ready   (stream.ready),
        .in_word    (stream.stream_word),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // decouple parser and builder so each may stall on its own
    dbc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // build words and drive the output register
    dbc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (pop_valid),
        .head_pop   (pop_ready),
        .head       (pop_data),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .out_word   (result.decoded_word),
        .out_last   (result.last_of_run)
    );

endmodule

`default_nettype wire

// ===== src/dbc_fifo.sv =====
// Short job queue between the code parser and the word builder.
// Depends on dbc_pkg for the job type and depth.
`default_nettype none

module dbc_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire dbc_pkg::dbc_op_t push_data,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output dbc_pkg::dbc_op_t     pop_data
);

    dbc_pkg::dbc_op_t                     mem_reg [dbc_pkg::FIFO_DEPTH];
    logic [dbc_pkg::FIFO_PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [dbc_pkg::FIFO_PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [dbc_pkg::FIFO_CNT_W-1:0]       cnt_reg, cnt_next;
    logic                                 do_push, do_pop;

    assign push_ready = (cnt_reg != dbc_pkg::FIFO_CNT_W'(dbc_pkg::FIFO_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg
                    + dbc_pkg::FIFO_CNT_W'(do_push)
                    - dbc_pkg::FIFO_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/dbc_front.sv =====
// Code parser: takes stream words, parses one code a cycle from the bit buffer unless
// the job queue is full, and queues jobs for the word builder. Depends on dbc_pkg.
`default_nettype none

module dbc_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [dbc_pkg::WORD_W-1:0] in_word,
    output logic                            push_valid,
    input  wire logic                       push_ready,
    output dbc_pkg::dbc_op_t                push_data
);

    dbc_pkg::fe_state_t               state_reg, state_next;
    logic [dbc_pkg::BUF_W-1:0]        buf_reg, buf_next;
    logic [dbc_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [dbc_pkg::RES_CNT_W-1:0]    n_reg, n_next;
    logic                             stopped_reg, stopped_next;

    dbc_pkg::fmt_t                    fmt;
    logic [dbc_pkg::LEN_W-1:0]        len;
    logic                             have_fmt, complete, room;
    logic                             end_scan, is_stop, code_ok;
    logic                             done, consume, accept;
    logic [4:0]                       pos_p, pos_q;
    logic [2:0]                       rep_cnt;
    logic [dbc_pkg::RES_CNT_W-1:0]    rem, emit_cnt, n_inc;

    assign fmt      = dbc_pkg::fmt_t'(buf_reg[65:63]);
    assign len      = dbc_pkg::code_length(fmt);
    assign have_fmt = (cnt_reg >= dbc_pkg::CNT_W'(3));
    assign complete = (cnt_reg >= dbc_pkg::CNT_W'(len));
    assign room     = (n_reg < dbc_pkg::RES_CNT_W'(dbc_pkg::MAX_RESULTS));
    assign is_stop  = have_fmt && (fmt == dbc_pkg::FMT_STOP);
    assign end_scan = !have_fmt || (fmt != dbc_pkg::FMT_STOP && !complete);
    assign code_ok  = have_fmt && (fmt != dbc_pkg::FMT_STOP) && complete;
    assign accept   = in_valid && in_ready;

    assign pos_p    = buf_reg[62:58];
    assign pos_q    = buf_reg[57:53];
    assign rep_cnt  = {1'b0, buf_reg[62:61]} + 3'd1;
    assign rem      = dbc_pkg::RES_CNT_W'(dbc_pkg::MAX_RESULTS) - n_reg;
    assign emit_cnt = (dbc_pkg::RES_CNT_W'(rep_cnt) < rem)
                    ? dbc_pkg::RES_CNT_W'(rep_cnt) : rem;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dbc_pkg::FE_IDLE:
            begin
                if (accept && !stopped_reg)
                begin
                    state_next = dbc_pkg::FE_PARSE;
                end
            end
            dbc_pkg::FE_PARSE:
            begin
                if (done)
                begin
                    state_next = dbc_pkg::FE_IDLE;
                end
            end
            default: state_next = dbc_pkg::FE_IDLE;
        endcase
    end

    // Outputs and job building
    always_comb
    begin
        in_ready   = (state_reg == dbc_pkg::FE_IDLE);
        push_valid = (state_reg == dbc_pkg::FE_PARSE)
                   && (end_scan || is_stop || (code_ok && room));
        done       = (state_reg == dbc_pkg::FE_PARSE) && (end_scan || is_stop) && push_ready;
        consume    = (state_reg == dbc_pkg::FE_PARSE) && code_ok && (!room || push_ready);

        push_data.kind       = dbc_pkg::OP_WORD;
        push_data.use_dict   = 1'b1;
        push_data.dict_idx   = '0;
        push_data.value      = '0;
        push_data.rep_cnt_m1 = '0;
        n_inc                = dbc_pkg::RES_CNT_W'(1);

        if (end_scan || is_stop)
        begin
            push_data.kind = dbc_pkg::OP_END;
        end
        else
        begin
            unique case (fmt)
                dbc_pkg::FMT_REPEAT:
                begin
                    push_data.kind       = dbc_pkg::OP_REPEAT;
                    push_data.rep_cnt_m1 = 2'(emit_cnt - dbc_pkg::RES_CNT_W'(1));
                    n_inc                = emit_cnt;
                end
                dbc_pkg::FMT_MASK:
                begin
                    push_data.value    = {buf_reg[57:54], 28'b0} >> pos_p;
                    push_data.dict_idx = buf_reg[53:51];
                end
                dbc_pkg::FMT_FLIP:
                begin
                    push_data.value    = 32'h8000_0000 >> pos_p;
                    push_data.dict_idx = buf_reg[57:55];
                end
                dbc_pkg::FMT_ADJ:
                begin
                    // a pair starting at the last bit leaves the word alone
                    push_data.value    = (pos_p == 5'd31) ? 32'h0 : (32'hC000_0000 >> pos_p);
                    push_data.dict_idx = buf_reg[57:55];
                end
                dbc_pkg::FMT_TWO:
                begin
                    push_data.value    = (32'h8000_0000 >> pos_p) | (32'h8000_0000 >> pos_q);
                    push_data.dict_idx = buf_reg[52:50];
                end
                dbc_pkg::FMT_DIRECT:
                begin
                    push_data.dict_idx = buf_reg[62:60];
                end
                dbc_pkg::FMT_RAW:
                begin
                    push_data.use_dict = 1'b0;
                    push_data.value    = buf_reg[62:31];
                end
                dbc_pkg::FMT_STOP:
                begin
                    push_data.kind = dbc_pkg::OP_END;
                end
                default:
                begin
                    push_data.kind = dbc_pkg::OP_END;
                end
            endcase
        end

        buf_next     = buf_reg;
        cnt_next     = cnt_reg;
        n_next       = n_reg;
        stopped_next = stopped_reg;

        if (accept && !stopped_reg)
        begin
            // append below the leftover bits, which sit at the top of the buffer
            buf_next = buf_reg | ({in_word, {dbc_pkg::LEFT_MAX{1'b0}}} >> cnt_reg);
            cnt_next = cnt_reg + dbc_pkg::CNT_W'(dbc_pkg::WORD_W);
            n_next   = '0;
        end
        else if (done && is_stop)
        begin
            stopped_next = 1'b1;
            buf_next     = '0;
            cnt_next     = '0;
        end
        else if (consume)
        begin
            buf_next = buf_reg << len;
            cnt_next = cnt_reg - dbc_pkg::CNT_W'(len);
            if (room)
            begin
                n_next = n_reg + n_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= dbc_pkg::FE_IDLE;
            buf_reg     <= '0;
            cnt_reg     <= '0;
            n_reg       <= '0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            buf_reg     <= buf_next;
            cnt_reg     <= cnt_next;
            n_reg       <= n_next;
            stopped_reg <= stopped_next;
        end
    end

    a_idle_left: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dbc_pkg::FE_IDLE |-> cnt_reg <= dbc_pkg::CNT_W'(dbc_pkg::LEFT_MAX))
        else $error("leftover bits exceed the longest incomplete code");

    a_res_cap: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= dbc_pkg::RES_CNT_W'(dbc_pkg::MAX_RESULTS))
        else $error("result count past its cap");

    a_stop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |-> cnt_reg == '0 && state_reg == dbc_pkg::FE_IDLE)
        else $error("bits buffered or parsing after stop");

endmodule

`default_nettype wire

// ===== src/dbc_back.sv =====
// Word builder: runs queued jobs against the dictionary and previous word,
// holds one result back to mark the last of a run. Depends on dbc_pkg.
`default_nettype none

module dbc_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire dbc_pkg::cfg_wr_t           cfg,
    input  wire logic                       head_valid,
    output logic                            head_pop,
    input  wire dbc_pkg::dbc_op_t           head,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [dbc_pkg::WORD_W-1:0]      out_word,
    output logic                            out_last
);

    logic [dbc_pkg::WORD_W-1:0] dict_reg [dbc_pkg::DICT_DEPTH];
    logic [dbc_pkg::WORD_W-1:0] prev_reg, prev_next;
    logic [1:0]                 rep_reg, rep_next;
    logic                       pend_valid_reg, pend_valid_next;
    logic [dbc_pkg::WORD_W-1:0] pend_word_reg, pend_word_next;
    logic                       out_valid_reg, out_valid_next;
    logic [dbc_pkg::WORD_W-1:0] out_word_reg, out_word_next;
    logic                       out_last_reg, out_last_next;

    logic                       out_free, can_shift, fire;
    logic [dbc_pkg::WORD_W-1:0] built;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_last  = out_last_reg;

    assign out_free  = !out_valid_reg || out_ready;
    assign can_shift = !pend_valid_reg || out_free;
    assign fire      = head_valid && can_shift;

    always_comb
    begin
        built = head.use_dict ? (dict_reg[head.dict_idx] ^ head.value) : head.value;

        head_pop        = 1'b0;
        prev_next       = prev_reg;
        rep_next        = rep_reg;
        pend_valid_next = pend_valid_reg;
        pend_word_next  = pend_word_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_word_next   = out_word_reg;
        out_last_next   = out_last_reg;

        if (fire)
        begin
            // hand the held result on before taking a new one
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_word_next  = pend_word_reg;
                out_last_next  = (head.kind == dbc_pkg::OP_END);
            end
            unique case (head.kind)
                dbc_pkg::OP_WORD:
                begin
                    head_pop        = 1'b1;
                    prev_next       = built;
                    pend_valid_next = 1'b1;
                    pend_word_next  = built;
                end
                dbc_pkg::OP_REPEAT:
                begin
                    pend_valid_next = 1'b1;
                    pend_word_next  = prev_reg;
                    if (rep_reg == head.rep_cnt_m1)
                    begin
                        head_pop = 1'b1;
                        rep_next = '0;
                    end
                    else
                    begin
                        rep_next = rep_reg + 2'd1;
                    end
                end
                dbc_pkg::OP_END:
                begin
                    head_pop        = 1'b1;
                    pend_valid_next = 1'b0;
                end
                default:
                begin
                    head_pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dbc_pkg::DICT_DEPTH; i++)
            begin
                dict_reg[i] <= '0;
            end
            prev_reg       <= '0;
            rep_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.we)
            begin
                dict_reg[cfg.index] <= cfg.data;
            end
            prev_reg       <= prev_next;
            rep_reg        <= rep_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_word_reg <= pend_word_next;
        out_word_reg  <= out_word_next;
        out_last_reg  <= out_last_next;
    end

    a_rep_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid && head.kind == dbc_pkg::OP_REPEAT |-> rep_reg <= head.rep_cnt_m1)
        else $error("repeat counter past its count");

    a_rep_head: assert property (@(posedge clk) disable iff (!rst_n)
        rep_reg != 2'd0 |-> head_valid && head.kind == dbc_pkg::OP_REPEAT)
        else $error("repeat in progress without a repeat job");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        fire && pend_valid_reg |-> out_free)
        else $error("held result moved onto a stalled output");

endmodule

`default_nettype wire

// ===== verif/dbc_result_checker.sv =====
// Result checker of the decompressor: decodes every accepted stream word itself
// and compares each accepted result with the oldest decoded word still awaited.
// Depends on dbc_pkg, dbc_in_if and dbc_out_if.
module dbc_result_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [dbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dbc_pkg::WORD_W-1:0]    cfg_data,
    dbc_in_if                             stream,
    dbc_out_if                            result,
    output int                            mismatches,
    output int                            awaited
);
    timeunit 1ns;
    timeprecision 1ps;

    import dbc_pkg::*;

    logic [31:0] dict_copy [8];
    logic [33:0] held_bits;
    int unsigned held_count;
    logic [31:0] prev_word;
    bit          halted;

    logic [31:0] want_word_q [$];
    bit          want_last_q [$];

    int fail_count = 0;
    int queued     = 0;

    assign mismatches = fail_count;
    assign awaited    = queued;

    // Read n bits, first bit first, from index pos of the bit buffer.
    function automatic logic [31:0] pull_bits(input bit [0:65] bits, input int unsigned pos,
                                              input int unsigned n);
        logic [31:0] v;
        int unsigned k;
        v = '0;
        for (k = pos; k < pos + n; k++)
            v = {v[30:0], (k < 66) ? bits[k] : 1'b0};
        return v;
    endfunction

    function automatic int unsigned code_span(input fmt_t f);
        case (f)
            FMT_REPEAT: return 5;
            FMT_MASK:   return 15;
            FMT_FLIP:   return 11;
            FMT_ADJ:    return 11;
            FMT_TWO:    return 16;
            FMT_DIRECT: return 6;
            FMT_RAW:    return 35;
            default:    return 0;
        endcase
    endfunction

    // Build the word of any non-repeat code; position 0 is the word's top bit.
    function automatic logic [31:0] build_word(input bit [0:65] bits, input int unsigned pos,
                                               input fmt_t f);
        logic [4:0]  p;
        logic [4:0]  q;
        logic [3:0]  m;
        logic [2:0]  idx;
        logic [31:0] base;
        p = 5'(pull_bits(bits, pos + 3, 5));
        case (f)
            FMT_MASK:
            begin
                m    = 4'(pull_bits(bits, pos + 8, 4));
                idx  = 3'(pull_bits(bits, pos + 12, 3));
                base = dict_copy[idx];
                // mask bits shifted past the last position drop off
                return base ^ ({m, 28'b0} >> p);
            end
            FMT_FLIP:
            begin
                idx = 3'(pull_bits(bits, pos + 8, 3));
                return dict_copy[idx] ^ (32'h8000_0000 >> p);
            end
            FMT_ADJ:
            begin
                idx  = 3'(pull_bits(bits, pos + 8, 3));
                base = dict_copy[idx];
                if (p < 5'd31)
                    base = base ^ (32'hC000_0000 >> p);
                return base;
            end
            FMT_TWO:
            begin
                q   = 5'(pull_bits(bits, pos + 8, 5));
                idx = 3'(pull_bits(bits, pos + 13, 3));
                return dict_copy[idx] ^ ((32'h8000_0000 >> p) | (32'h8000_0000 >> q));
            end
            FMT_DIRECT:
            begin
                idx = 3'(pull_bits(bits, pos + 3, 3));
                return dict_copy[idx];
            end
            default:
                return pull_bits(bits, pos + 3, 32);
        endcase
    endfunction

    // Queue one awaited word, not yet marked as the last of its run.
    function automatic void queue_result(input logic [31:0] w);
        want_word_q.insert(want_word_q.size(), w);
        want_last_q.insert(want_last_q.size(), 1'b0);
    endfunction

    // Append one stream word to the held bits, decode every complete code and
    // queue the words it yields.
    function automatic void decode_stream_word(input logic [31:0] w);
        bit [0:65]   bits;
        int unsigned total;
        int unsigned pos;
        int unsigned len;
        int unsigned reps;
        int unsigned made;
        int unsigned i;
        fmt_t        code_fmt;
        if (halted)
            return;
        bits = '0;
        for (i = 0; i < held_count; i++)
            bits[i] = held_bits[held_count - 1 - i];
        for (i = 0; i < 32; i++)
            bits[held_count + i] = w[31 - i];
        total = held_count + 32;
        pos   = 0;
        made  = 0;
        while (total - pos >= 3) begin
            code_fmt = fmt_t'(3'(pull_bits(bits, pos, 3)));
            if (code_fmt == FMT_STOP) begin
                halted = 1'b1;
                pos    = total;
                break;
            end
            len = code_span(code_fmt);
            if (total - pos < len)
                break;
            if (code_fmt == FMT_REPEAT) begin
                reps = pull_bits(bits, pos + 3, 2) + 1;
                for (i = 0; i < reps && made < MAX_RESULTS; i++) begin
                    queue_result(prev_word);
                    made++;
                end
            end else if (made < MAX_RESULTS) begin
                prev_word = build_word(bits, pos, code_fmt);
                queue_result(prev_word);
                made++;
            end
            pos += len;
        end
        held_count = total - pos;
        if (held_count > 34)
            held_count = 34;
        held_bits = '0;
        for (i = 0; i < held_count; i++)
            held_bits = {held_bits[32:0], bits[pos + i]};
        if (made > 0)
            want_last_q[want_last_q.size() - 1] = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        logic [31:0] exp_word;
        bit          exp_last;
        if (!rst_n) begin
            foreach (dict_copy[i])
                dict_copy[i] = '0;
            held_bits  = '0;
            held_count = 0;
            prev_word  = '0;
            halted     = 1'b0;
            want_word_q.delete();
            want_last_q.delete();
            queued = 0;
        end else begin
            // results first: a word accepted at this edge cannot have caused one yet
            if (result.valid && result.ready) begin
                if (want_word_q.size() == 0) begin
                    $error("unexpected result: decoded_word %h, last_of_run %b",
                           result.decoded_word, result.last_of_run);
                    fail_count++;
                end else begin
                    exp_word = want_word_q.pop_front();
                    exp_last = want_last_q.pop_front();
                    if (result.decoded_word !== exp_word) begin
                        $error("decoded_word: expected %h, actual %h",
                               exp_word, result.decoded_word);
                        fail_count++;
                    end
                    if (result.last_of_run !== exp_last) begin
                        $error("last_of_run: expected %b, actual %b",
                               exp_last, result.last_of_run);
                        fail_count++;
                    end
                end
            end
            if (stream.valid && stream.ready)
                decode_stream_word(stream.stream_word);
            if (cfg_we)
                dict_copy[cfg_index] = cfg_data;
            queued = want_word_q.size();
        end
    end

endmodule

// ===== verif/tb_dictionary_bitmask_code_decompressor.sv =====
// Top of the decompressor testbench: clock, reset, dictionary writes and a stream
// of packed codes, with random idling on both channels and the final verdict.
// Depends on dbc_pkg, dbc_in_if, dbc_out_if, dbc_result_checker and the block.
module tb_dictionary_bitmask_code_decompressor;
    timeunit 1ns;
    timeprecision 1ps;

    import dbc_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    dbc_in_if  stream_ch ();
    dbc_out_if result_ch ();

    int mismatch_count;
    int awaited_count;

    // Stream bits packed but not yet sent as a whole word.
    bit          unsent_bits [$];
    int unsigned words_sent   = 0;
    bit          send_idle_on = 1'b0;
    bit          recv_idle_on = 1'b0;
    bit          calm         = 1'b0;
    logic [31:0] dict_vals [8];

    dictionary_bitmask_code_decompressor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stream    (stream_ch),
        .result    (result_ch)
    );

    dbc_result_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .stream     (stream_ch),
        .result     (result_ch),
        .mismatches (mismatch_count),
        .awaited    (awaited_count)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Result side: ready drops at random while idling is on.
    initial begin : receiver
        int hold;
        hold = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold > 0) begin
                result_ch.ready = 1'b0;
                hold--;
            end else if (recv_idle_on && $urandom_range(0, 7) == 0) begin
                result_ch.ready = 1'b0;
                hold = $urandom_range(1, 18) - 1;
            end else begin
                result_ch.ready = 1'b1;
            end
        end
    end

    // Offer one stream word and hold it until the request is taken. Entered and
    // left at a falling edge; valid stays high on return.
    task automatic push_stream_word(input logic [31:0] w);
        int gap;
        if (send_idle_on && $urandom_range(0, 3) == 0) begin
            stream_ch.valid = 1'b0;
            gap = $urandom_range(1, 18);
            repeat (gap) @(negedge clk);
        end
        stream_ch.valid       = 1'b1;
        stream_ch.stream_word = w;
        do
            @(posedge clk);
        while (!stream_ch.ready);
        @(negedge clk);
        words_sent++;
        // switch idling on and off now and then, so quiet stretches occur too
        if (!calm && words_sent % 25 == 0) begin
            send_idle_on = $urandom_range(0, 3) != 0;
            recv_idle_on = $urandom_range(0, 3) != 0;
        end
    endtask

    // Append n bits, top bit first, and send every whole word that forms.
    task automatic push_bits(input logic [31:0] v, input int unsigned n);
        int          i;
        int          j;
        logic [31:0] word;
        for (i = int'(n) - 1; i >= 0; i--)
            unsent_bits.insert(unsent_bits.size(), v[i]);
        while (unsent_bits.size() >= 32) begin
            word = '0;
            for (j = 0; j < 32; j++)
                word = {word[30:0], unsent_bits.pop_front()};
            push_stream_word(word);
        end
    endtask

    task automatic emit_code(input fmt_t f, input logic [31:0] fields, input int unsigned width);
        push_bits(32'(f), 3);
        push_bits(fields, width);
    endtask

    // Fill up to a word boundary with repeat and direct codes, so that the block
    // holds no bits afterwards; any gap of 20 bits or more splits into 5s and 6s.
    task automatic pad_to_word();
        int r;
        int b;
        r = (32 - int'(unsent_bits.size() % 32)) % 32;
        if (r == 0)
            return;
        if (r < 20)
            r += 32;
        b = 0;
        while ((r - 6 * b) % 5 != 0)
            b++;
        repeat (b) emit_code(FMT_DIRECT, $urandom_range(0, 7), 3);
        repeat ((r - 6 * b) / 5) emit_code(FMT_REPEAT, $urandom_range(0, 3), 2);
    endtask

    // One well-formed code with random content, leaning towards the edge positions.
    task automatic random_code();
        int          sel;
        logic [4:0]  p;
        logic [4:0]  q;
        logic [2:0]  d;
        logic [31:0] raw;
        sel = $urandom_range(0, 13);
        p   = ($urandom_range(0, 7) == 0) ? 5'd31 : 5'($urandom_range(0, 31));
        q   = ($urandom_range(0, 5) == 0) ? p : 5'($urandom_range(0, 31));
        d   = 3'($urandom_range(0, 7));
        case (sel)
            0, 1, 2:
                emit_code(FMT_REPEAT, $urandom_range(0, 3), 2);
            3, 4:
                emit_code(FMT_MASK, 32'({p, 4'($urandom_range(0, 15)), d}), 12);
            5, 6:
                emit_code(FMT_FLIP, 32'({p, d}), 8);
            7, 8:
                emit_code(FMT_ADJ, 32'({p, d}), 8);
            9, 10:
                emit_code(FMT_TWO, 32'({p, q, d}), 13);
            11, 12:
                emit_code(FMT_DIRECT, 32'(d), 3);
            default:
            begin
                case ($urandom_range(0, 5))
                    0:       raw = '0;
                    1:       raw = '1;
                    default: raw = $urandom;
                endcase
                emit_code(FMT_RAW, raw, 32);
            end
        endcase
    endtask

    // Write all eight dictionary entries, one per cycle.
    task automatic write_dictionary();
        int i;
        for (i = 0; i < 8; i++) begin
            cfg_we    = 1'b1;
            cfg_index = CFG_IDX_W'(i);
            cfg_data  = dict_vals[i];
            @(negedge clk);
        end
        cfg_we = 1'b0;
    endtask

    // Hold the stream until every awaited word is out, then let the parser settle.
    task automatic drain_results();
        stream_ch.valid = 1'b0;
        while (awaited_count != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic run_random_phase(input int unsigned until_words);
        while (words_sent < until_words)
            random_code();
        pad_to_word();
    endtask

    initial begin : stimulus
        int i;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        stream_ch.valid       = 1'b0;
        stream_ch.stream_word = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part: edge patterns in the dictionary, then every format.
        dict_vals = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0001, 32'hA5A5_A5A5,
                      32'h5A5A_5A5A, 32'h1234_5678, 32'hFEDC_BA98, 32'h0F0F_0F0F};
        write_dictionary();

        // repeat before any word decoded: zeros
        emit_code(FMT_REPEAT, 32'd3, 2);
        emit_code(FMT_MASK, 32'({5'd0, 4'hF, 3'd1}), 12);
        // mask running past the last position
        emit_code(FMT_MASK, 32'({5'd29, 4'hF, 3'd3}), 12);
        emit_code(FMT_MASK, 32'({5'd31, 4'h9, 3'd0}), 12);
        emit_code(FMT_FLIP, 32'({5'd0, 3'd1}), 8);
        emit_code(FMT_FLIP, 32'({5'd31, 3'd0}), 8);
        emit_code(FMT_ADJ, 32'({5'd0, 3'd2}), 8);
        emit_code(FMT_ADJ, 32'({5'd30, 3'd3}), 8);
        // adjacent flip at the last position leaves the word alone
        emit_code(FMT_ADJ, 32'({5'd31, 3'd1}), 8);
        // both flips on the same bit
        emit_code(FMT_TWO, 32'({5'd5, 5'd5, 3'd4}), 13);
        emit_code(FMT_TWO, 32'({5'd0, 5'd31, 3'd7}), 13);
        for (i = 0; i < 8; i++)
            emit_code(FMT_DIRECT, i, 3);
        emit_code(FMT_RAW, 32'hFFFF_FFFF, 32);
        emit_code(FMT_RAW, 32'h0000_0000, 32);
        emit_code(FMT_RAW, 32'h8000_0001, 32);
        emit_code(FMT_REPEAT, 32'd0, 2);
        pad_to_word();
        // seven longest repeats, which spill past the first stream word
        repeat (7) emit_code(FMT_REPEAT, 32'd3, 2);
        pad_to_word();
        // an all-zero stream word
        repeat (7) emit_code(FMT_REPEAT, 32'd0, 2);
        pad_to_word();
        drain_results();

        // Random phases, with the dictionary changed between them.
        foreach (dict_vals[k])
            dict_vals[k] = $urandom;
        write_dictionary();
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        run_random_phase(110);
        drain_results();

        foreach (dict_vals[k])
            dict_vals[k] = 32'hFFFF_FFFF;
        write_dictionary();
        run_random_phase(200);
        drain_results();

        foreach (dict_vals[k])
            dict_vals[k] = 32'h0000_0000;
        write_dictionary();
        run_random_phase(290);
        drain_results();

        foreach (dict_vals[k])
            dict_vals[k] = $urandom;
        write_dictionary();
        // last stretch at full rate on both sides
        calm         = 1'b1;
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        run_random_phase(370);

        // Stop code after a direct code; the rest of the word and all later
        // words are dropped.
        emit_code(FMT_DIRECT, $urandom_range(0, 7), 3);
        emit_code(FMT_STOP, '0, 0);
        while (unsent_bits.size() % 32 != 0)
            push_bits($urandom_range(0, 1), 1);
        push_stream_word(32'hFFFF_FFFF);
        repeat (8) push_stream_word($urandom);
        stream_ch.valid = 1'b0;

        while (awaited_count != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (mismatch_count == 0 && awaited_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
